// File: design/tpc_pkg.sv
// Shared types, widths and register codes for the triangle plane clipper.
package tpc_pkg;

	localparam int COORD_W       = 24;
	localparam int NRM_W         = 18;
	localparam int OFS_W         = 24;
	localparam int TAG_W         = 16;
	localparam int CFG_W         = 24;
	localparam int CFG_IDX_W     = 2;
	localparam int FRAC_BITS_DEF = 16;

	// divider lane stages: multiply stage, one stage per quotient bit, final add
	localparam int CUT_LAT = COORD_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 2'd3;

	localparam logic signed [NRM_W-1:0] NORMAL_X_RST     = '0;
	localparam logic signed [NRM_W-1:0] NORMAL_Y_RST     = '0;
	localparam logic signed [NRM_W-1:0] NORMAL_Z_RST     = 18'sd65536;
	localparam logic signed [OFS_W-1:0] PLANE_OFFSET_RST = '0;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vtx_t;

	typedef struct packed {
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
		logic [TAG_W-1:0] tri_tag;
	} tri_in_t;

	typedef struct packed {
		coord_t out_a_x;
		coord_t out_a_y;
		coord_t out_a_z;
		coord_t out_b_x;
		coord_t out_b_y;
		coord_t out_b_z;
		coord_t out_c_x;
		coord_t out_c_y;
		coord_t out_c_z;
		logic [TAG_W-1:0] out_tag;
		logic last_of_run;
	} tri_out_t;

	typedef enum logic [1:0] {
		CLIP_DROP,
		CLIP_PASS,
		CLIP_ONE,
		CLIP_TWO
	} clip_mode_t;

	// what travels beside the divider lanes
	typedef struct packed {
		clip_mode_t mode;
		vtx_t apex;
		vtx_t second;
		logic [TAG_W-1:0] tag;
	} tri_side_t;

	// signed distance width: floored dot product or offset, plus one for the add
	function automatic int dist_width(input int frac);
		int sh;
		sh = NRM_W + COORD_W + 2 - frac;
		return ((sh > OFS_W) ? sh : OFS_W) + 1;
	endfunction

endpackage

// File: design/tpc_dist_lane.sv
// One distance lane: signed distance of a vertex to the plane, two stages.
module tpc_dist_lane #(
	parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
	input  logic                                           clk,
	input  tpc_pkg::vtx_t                                  vtx,
	input  logic signed [tpc_pkg::NRM_W-1:0]               nx,
	input  logic signed [tpc_pkg::NRM_W-1:0]               ny,
	input  logic signed [tpc_pkg::NRM_W-1:0]               nz,
	input  logic signed [tpc_pkg::OFS_W-1:0]               ofs,
	output logic signed [tpc_pkg::dist_width(FRAC_BITS)-1:0] d_out
);
	import tpc_pkg::*;

	localparam int PROD_W = NRM_W + COORD_W;
	localparam int DOT_W  = PROD_W + 2;
	localparam int D_W    = dist_width(FRAC_BITS);

	logic signed [PROD_W-1:0] px_s1, py_s1, pz_s1;
	logic signed [DOT_W-1:0]  dot, dot_fl;
	logic signed [D_W-1:0]    d_s2;

	always_ff @(posedge clk) begin
		px_s1 <= nx * vtx.x;
		py_s1 <= ny * vtx.y;
		pz_s1 <= nz * vtx.z;
	end

	always_comb begin
		dot    = DOT_W'(px_s1) + DOT_W'(py_s1) + DOT_W'(pz_s1);
		dot_fl = dot >>> FRAC_BITS;   // arithmetic shift floors
	end

	always_ff @(posedge clk) begin
		d_s2 <= D_W'(dot_fl) + D_W'(ofs);
	end

	assign d_out = d_s2;

endmodule

// File: design/tpc_cut_lane.sv
// One coordinate of an edge crossing: p_i + trunc(d_i*e/den), pipelined restoring divide.
module tpc_cut_lane #(
	parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
	input  logic                                             clk,
	input  tpc_pkg::coord_t                                  pi,
	input  logic signed [tpc_pkg::COORD_W:0]                 e,
	input  logic [tpc_pkg::dist_width(FRAC_BITS)-2:0]        di,
	input  logic [tpc_pkg::dist_width(FRAC_BITS)-1:0]        den,
	output tpc_pkg::coord_t                                  res
);
	import tpc_pkg::*;

	localparam int D_W   = dist_width(FRAC_BITS);
	localparam int Q_W   = COORD_W;
	localparam int NUM_W = D_W - 1 + Q_W;

	logic [Q_W-1:0]   mag;
	logic [NUM_W-1:0] num;

	logic [D_W-1:0] rem_s [Q_W+1];
	logic [Q_W-1:0] low_s [Q_W+1];
	logic [D_W-1:0] den_s [Q_W+1];
	coord_t         pi_s  [Q_W+1];
	logic           neg_s [Q_W+1];

	logic signed [COORD_W:0] qs;
	coord_t                  res_q;

	assign mag = e[COORD_W] ? Q_W'(-e) : Q_W'(e);
	assign num = di * mag;

	// quotient never exceeds |e|, so the top part of num starts below den
	always_ff @(posedge clk) begin
		rem_s[0] <= D_W'(num[NUM_W-1:Q_W]);
		low_s[0] <= num[Q_W-1:0];
		den_s[0] <= den;
		pi_s[0]  <= pi;
		neg_s[0] <= e[COORD_W];
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_div
		logic [D_W:0] trial, diff;
		logic         ge;

		always_comb begin
			trial = {rem_s[k], low_s[k][Q_W-1]};
			diff  = trial - {1'b0, den_s[k]};
			ge    = (trial >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
			low_s[k+1] <= {low_s[k][Q_W-2:0], ge};
			den_s[k+1] <= den_s[k];
			pi_s[k+1]  <= pi_s[k];
			neg_s[k+1] <= neg_s[k];
		end
	end

	assign qs = neg_s[Q_W] ? -$signed({1'b0, low_s[Q_W]}) : $signed({1'b0, low_s[Q_W]});

	always_ff @(posedge clk) begin
		res_q <= COORD_W'((COORD_W+1)'(pi_s[Q_W]) + qs);
	end

	assign res = res_q;

endmodule

// File: design/tpc_merge.sv
// Merge stage: builds output triangles from apex, side vertex and the two crossings.
module tpc_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  tpc_pkg::tri_side_t side,
	input  tpc_pkg::vtx_t      p3,
	input  tpc_pkg::vtx_t      p4,
	output logic               done,
	output tpc_pkg::tri_out_t  result
);
	import tpc_pkg::*;

	logic     done_q, pend_q;
	tri_out_t res_q, hold_q, first;

	function automatic tri_out_t mk_tri(input vtx_t a, input vtx_t b, input vtx_t c,
	                                    input logic [TAG_W-1:0] tag, input logic last);
		tri_out_t t;
		t.out_a_x = a.x; t.out_a_y = a.y; t.out_a_z = a.z;
		t.out_b_x = b.x; t.out_b_y = b.y; t.out_b_z = b.z;
		t.out_c_x = c.x; t.out_c_y = c.y; t.out_c_z = c.z;
		t.out_tag = tag;
		t.last_of_run = last;
		return t;
	endfunction

	always_comb begin
		unique case (side.mode)
			CLIP_PASS: first = mk_tri(side.apex, side.second, p3, side.tag, 1'b1);
			CLIP_TWO:  first = mk_tri(side.apex, side.second, p3, side.tag, 1'b0);
			CLIP_ONE:  first = mk_tri(side.apex, p3, p4, side.tag, 1'b1);
			default:   first = mk_tri(side.apex, p3, p4, side.tag, 1'b1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			done_q <= (in_valid && side.mode != CLIP_DROP) || pend_q;
			pend_q <= in_valid && side.mode == CLIP_TWO;
		end
	end

	// quad: second triangle follows in the next cycle
	always_ff @(posedge clk) begin
		if (in_valid) begin
			res_q  <= first;
			hold_q <= mk_tri(side.apex, p3, p4, side.tag, 1'b1);
		end else begin
			res_q <= hold_q;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !in_valid)
		else $error("item arrived while second triangle pending");

	a_pend_emits_last: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> (done && result.last_of_run))
		else $error("pending triangle not emitted as last");

	a_not_last_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.last_of_run) |=> done)
		else $error("run ended without last triangle");

endmodule

// File: design/triangle_plane_clipper.sv
// Top level: clips one triangle per item against a configured plane.
//
//  channel   signals                          meaning
//  ------    -------------------------------  -----------------------------------
//  item in   start, busy, triangle            taken when start && !busy
//  result    done, result                     one triangle per done cycle
//  config    cfg_we, cfg_index, cfg_data      register write, no wait
//
// An item is taken only while busy is low; busy is high the cycle after a take, so
// no item is taken in that cycle. The first result passes the registers of product,
// distance, classify, the COORD_W+2 divider stages and merge; the product stage loads
// at the take edge. A cut quad emits its second triangle in the following cycle.
// Reset loads the config reset values and clears the valid line; results cannot be stalled.
module triangle_plane_clipper #(
	parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  tpc_pkg::tri_in_t                triangle,
	output logic                            done,
	output tpc_pkg::tri_out_t               result,
	input  logic                            cfg_we,
	input  logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tpc_pkg::CFG_W-1:0]       cfg_data
);
	import tpc_pkg::*;

	localparam int D_W = dist_width(FRAC_BITS);

	logic signed [NRM_W-1:0] nx_q, ny_q, nz_q;
	logic signed [OFS_W-1:0] ofs_q;

	logic acc, busy_q;
	logic valid_s1, valid_s2, valid_s3;

	vtx_t             vin [3];
	vtx_t             vtx_s1 [3];
	vtx_t             vtx_s2 [3];
	logic [TAG_W-1:0] tag_s1, tag_s2;
	logic signed [D_W-1:0] dist_s2 [3];

	logic [2:0]  pos, neg;
	logic [1:0]  ia, ib, i3, j3, i4, j4;
	clip_mode_t  mode;
	logic [1:0]  ci [2];
	logic [1:0]  cj [2];

	tri_side_t               side_s3;
	coord_t                  lpi_s3 [2][3];
	logic signed [COORD_W:0] le_s3  [2][3];
	logic [D_W-2:0]          ldi_s3 [2];
	logic [D_W-1:0]          lden_s3 [2];

	coord_t    cres [2][3];
	tri_side_t side_dl [CUT_LAT];
	logic      vld_dl  [CUT_LAT];
	vtx_t      p3, p4;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q  <= NORMAL_X_RST;
			ny_q  <= NORMAL_Y_RST;
			nz_q  <= NORMAL_Z_RST;
			ofs_q <= PLANE_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NORMAL_X:     nx_q  <= cfg_data[NRM_W-1:0];
				REG_NORMAL_Y:     ny_q  <= cfg_data[NRM_W-1:0];
				REG_NORMAL_Z:     nz_q  <= cfg_data[NRM_W-1:0];
				REG_PLANE_OFFSET: ofs_q <= cfg_data[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	assign acc  = start && !busy_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			busy_q   <= acc;
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		vin[0] = '{x: triangle.a_x, y: triangle.a_y, z: triangle.a_z};
		vin[1] = '{x: triangle.b_x, y: triangle.b_y, z: triangle.b_z};
		vin[2] = '{x: triangle.c_x, y: triangle.c_y, z: triangle.c_z};
	end

	always_ff @(posedge clk) begin
		vtx_s1 <= vin;
		tag_s1 <= triangle.tri_tag;
		vtx_s2 <= vtx_s1;
		tag_s2 <= tag_s1;
	end

	for (genvar i = 0; i < 3; i++) begin : g_dist
		tpc_dist_lane #(.FRAC_BITS(FRAC_BITS)) u_dist (
			.clk   (clk),
			.vtx   (vin[i]),
			.nx    (nx_q),
			.ny    (ny_q),
			.nz    (nz_q),
			.ofs   (ofs_q),
			.d_out (dist_s2[i])
		);
	end

	// classify: apex, second vertex and the two cut edges
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pos[k] = dist_s2[k] > 0;
			neg[k] = dist_s2[k] < 0;
		end
		ia = 2'd0; ib = 2'd1;
		i3 = 2'd2; j3 = 2'd2; i4 = 2'd2; j4 = 2'd2;
		priority if (neg == 3'b000) begin
			mode = CLIP_PASS;
		end else if (pos == 3'b000) begin
			mode = CLIP_DROP;
		end else if (pos[0] && pos[1]) begin
			mode = CLIP_TWO; ia = 2'd0; ib = 2'd1;
			i3 = 2'd1; j3 = 2'd2; i4 = 2'd0; j4 = 2'd2;
		end else if (pos[1] && pos[2]) begin
			mode = CLIP_TWO; ia = 2'd1; ib = 2'd2;
			i3 = 2'd2; j3 = 2'd0; i4 = 2'd1; j4 = 2'd0;
		end else if (pos[0] && pos[2]) begin
			mode = CLIP_TWO; ia = 2'd2; ib = 2'd0;
			i3 = 2'd0; j3 = 2'd1; i4 = 2'd2; j4 = 2'd1;
		end else if (pos[0]) begin
			mode = CLIP_ONE; ia = 2'd0;
			i3 = 2'd0; j3 = 2'd1; i4 = 2'd0; j4 = 2'd2;
		end else if (pos[1]) begin
			mode = CLIP_ONE; ia = 2'd1;
			i3 = 2'd1; j3 = 2'd2; i4 = 2'd1; j4 = 2'd0;
		end else begin
			mode = CLIP_ONE; ia = 2'd2;
			i3 = 2'd2; j3 = 2'd0; i4 = 2'd2; j4 = 2'd1;
		end
		ci[0] = i3; cj[0] = j3;
		ci[1] = i4; cj[1] = j4;
	end

	// pass-through: both lanes see zero numerator so they return c
	always_ff @(posedge clk) begin
		side_s3.mode   <= mode;
		side_s3.apex   <= vtx_s2[ia];
		side_s3.second <= vtx_s2[ib];
		side_s3.tag    <= tag_s2;
		for (int l = 0; l < 2; l++) begin
			lpi_s3[l][0] <= vtx_s2[ci[l]].x;
			lpi_s3[l][1] <= vtx_s2[ci[l]].y;
			lpi_s3[l][2] <= vtx_s2[ci[l]].z;
			le_s3[l][0]  <= (COORD_W+1)'(vtx_s2[cj[l]].x) - (COORD_W+1)'(vtx_s2[ci[l]].x);
			le_s3[l][1]  <= (COORD_W+1)'(vtx_s2[cj[l]].y) - (COORD_W+1)'(vtx_s2[ci[l]].y);
			le_s3[l][2]  <= (COORD_W+1)'(vtx_s2[cj[l]].z) - (COORD_W+1)'(vtx_s2[ci[l]].z);
			if (mode == CLIP_PASS || mode == CLIP_DROP) begin
				ldi_s3[l]  <= '0;
				lden_s3[l] <= D_W'(1);
			end else begin
				ldi_s3[l]  <= dist_s2[ci[l]][D_W-2:0];
				lden_s3[l] <= D_W'(dist_s2[ci[l]] - dist_s2[cj[l]]);
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_cut
		for (genvar c = 0; c < 3; c++) begin : g_coord
			tpc_cut_lane #(.FRAC_BITS(FRAC_BITS)) u_cut (
				.clk (clk),
				.pi  (lpi_s3[l][c]),
				.e   (le_s3[l][c]),
				.di  (ldi_s3[l]),
				.den (lden_s3[l]),
				.res (cres[l][c])
			);
		end
	end

	// sideband line matching the divider lane latency
	always_ff @(posedge clk) begin
		side_dl[0] <= side_s3;
		for (int k = 1; k < CUT_LAT; k++) begin
			side_dl[k] <= side_dl[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CUT_LAT; k++) begin
				vld_dl[k] <= 1'b0;
			end
		end else begin
			vld_dl[0] <= valid_s3;
			for (int k = 1; k < CUT_LAT; k++) begin
				vld_dl[k] <= vld_dl[k-1];
			end
		end
	end

	always_comb begin
		p3 = '{x: cres[0][0], y: cres[0][1], z: cres[0][2]};
		p4 = '{x: cres[1][0], y: cres[1][1], z: cres[1][2]};
	end

	tpc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_dl[CUT_LAT-1]),
		.side     (side_dl[CUT_LAT-1]),
		.p3       (p3),
		.p4       (p4),
		.done     (done),
		.result   (result)
	);

endmodule
